// ===== src/cal_pkg.sv =====
// ----------------------------------------------------------------------------
// cal_pkg: shared types and codes for the cursor array list
// Operation kinds, status codes, control state and cell control bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package cal_pkg;

    // Operation kinds carried in the kind field
    localparam logic [2:0] KIND_CLEAR    = 3'd0;
    localparam logic [2:0] KIND_INSERT   = 3'd1;
    localparam logic [2:0] KIND_APPEND   = 3'd2;
    localparam logic [2:0] KIND_TO_START = 3'd3;
    localparam logic [2:0] KIND_TO_END   = 3'd4;
    localparam logic [2:0] KIND_BACK     = 3'd5;
    localparam logic [2:0] KIND_FORWARD  = 3'd6;
    localparam logic [2:0] KIND_MOVE     = 3'd7;

    // Result status codes
    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_FULL  = 2'd1;
    localparam logic [1:0] STATUS_RANGE = 2'd2;

    // Field widths of the transactions
    localparam int unsigned KIND_W   = 3;
    localparam int unsigned VALUE_W  = 32;
    localparam int unsigned POS_W    = 8;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned S_TDATA_W = 48;
    localparam int unsigned M_TDATA_W = 56;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_BUSY = 3'b010,
        ST_HOLD = 3'b100
    } state_t;

    // Per-cycle command broadcast along the cell row
    typedef struct packed {
        logic ins;    // shift the tail up and write at the cursor
        logic app;    // write at the end of the list
        logic rd_en;  // cursor lies below the length
    } cell_ctl_t;

endpackage

`default_nettype wire

// ===== src/cal_cell.sv =====
// ----------------------------------------------------------------------------
// cal_cell: one storage cell of the list row
// Holds one entry; takes its left neighbour on insert, new data at its slot.
// ----------------------------------------------------------------------------
`default_nettype none

module cal_cell #(
    parameter int unsigned IDX        = 0,
    parameter int unsigned CNT_W      = 8,
    parameter int unsigned DATA_WIDTH = 32
) (
    input  wire logic                  aclk,
    input  wire cal_pkg::cell_ctl_t    ctl,
    input  wire logic [CNT_W-1:0]      cursor,
    input  wire logic [CNT_W-1:0]      count,
    input  wire logic [DATA_WIDTH-1:0] wr_data,
    input  wire logic [DATA_WIDTH-1:0] left_data,
    output logic      [DATA_WIDTH-1:0] data,
    output logic      [DATA_WIDTH-1:0] rd_data
);

    localparam logic [CNT_W-1:0] MY_IDX = CNT_W'(IDX);

    logic [DATA_WIDTH-1:0] data_reg;
    logic [DATA_WIDTH-1:0] data_next;
    logic                  at_cursor;

    assign at_cursor = (cursor == MY_IDX);

    always_comb begin
        data_next = data_reg;
        if (ctl.ins) begin
            if (at_cursor) begin
                data_next = wr_data;
            end else if ((MY_IDX > cursor) && (MY_IDX <= count)) begin
                data_next = left_data;
            end
        end else if (ctl.app && (count == MY_IDX)) begin
            data_next = wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign data    = data_reg;
    // present the entry only when this cell sits under a valid cursor
    assign rd_data = (ctl.rd_en && at_cursor) ? data_reg : '0;

endmodule

`default_nettype wire

// ===== src/cal_rd_tree.sv =====
// ----------------------------------------------------------------------------
// cal_rd_tree: registered OR tree gathering the entry under the cursor
// At most one leaf is non-zero; each level is registered.
// ----------------------------------------------------------------------------
`default_nettype none

module cal_rd_tree #(
    parameter int unsigned LEAVES = 128,
    parameter int unsigned LVLS   = 7,
    parameter int unsigned WIDTH  = 32
) (
    input  wire logic             aclk,
    input  wire logic [WIDTH-1:0] leaf [LEAVES],
    output logic      [WIDTH-1:0] root
);

    localparam int unsigned NL = 1 << LVLS;

    // heap order: node 1 is the root, nodes NL .. 2*NL-1 are the leaves
    logic [WIDTH-1:0] node_reg [1:2*NL-1];

    genvar k;
    generate
        for (k = 1; k < 2 * NL; k++) begin : g_node
            if (k >= NL) begin : g_leaf
                if ((k - NL) < LEAVES) begin : g_used
                    always_ff @(posedge aclk) begin
                        node_reg[k] <= leaf[k - NL];
                    end
                end else begin : g_pad
                    always_ff @(posedge aclk) begin
                        node_reg[k] <= '0;
                    end
                end
            end else begin : g_inner
                always_ff @(posedge aclk) begin
                    node_reg[k] <= node_reg[2 * k] | node_reg[2 * k + 1];
                end
            end
        end
    endgenerate

    assign root = node_reg[1];

endmodule

`default_nettype wire

// ===== src/cursor_array_list.sv =====
// ----------------------------------------------------------------------------
// cursor_array_list: array-based list with a cursor
// Row of storage cells plus a registered read tree and an output register.
// ----------------------------------------------------------------------------
// The list is held in a row of CAPACITY cells, one entry each. An operation
// (clear, insert at the cursor, append, to start, to end, back, forward,
// move to position) is applied in the cycle its transaction is accepted:
// on insert every cell above the cursor and up to the length takes its
// left neighbour's entry in the same cycle and the cursor cell takes the
// new value. The entry under the cursor is then gathered through a
// registered OR tree of $clog2(CAPACITY) levels and loaded into the output
// register; s_tready is high only while the sequencer is idle, so the next
// transaction is accepted only after the load, and later while a waiting
// result holds the load back. The result register decouples the output: a
// new operation is accepted while the previous result waits.
// Insert or append on a full list reports status 1, a move beyond the length
// reports status 2; both leave the list untouched. No clearing pass is run
// after reset: entries beyond the length are never presented.
// ----------------------------------------------------------------------------
`default_nettype none

module cursor_array_list #(
    parameter int unsigned CAPACITY   = 128,
    parameter int unsigned DATA_WIDTH = 32
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // [2:0] kind, [34:3] item_value, [42:35] target_position, [47:43] zero
    input  wire logic [47:0] s_tdata,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [1:0] status, [9:2] list_length, [17:10] cursor_position,
    // [49:18] cursor_value, [50] cursor_valid, [55:51] zero
    output logic      [55:0] m_tdata
);

    localparam int unsigned CNT_W  = $clog2(CAPACITY + 1);
    localparam int unsigned CMP_W  = (CNT_W > cal_pkg::POS_W) ? CNT_W : cal_pkg::POS_W;
    localparam int unsigned LVLS   = $clog2(CAPACITY);
    localparam int unsigned LAT    = LVLS + 1;
    localparam int unsigned WAIT_W = $clog2(LAT + 1);
    localparam logic [CNT_W-1:0]  CAP_C    = CNT_W'(CAPACITY);
    localparam logic [WAIT_W-1:0] WAIT_INI = WAIT_W'(LAT);

    // unpack the input transaction
    logic [cal_pkg::KIND_W-1:0]  in_kind;
    logic [cal_pkg::VALUE_W-1:0] in_value;
    logic [cal_pkg::POS_W-1:0]   in_target;

    assign in_kind   = s_tdata[2:0];
    assign in_value  = s_tdata[34:3];
    assign in_target = s_tdata[42:35];

    // control state
    cal_pkg::state_t           state_reg, state_next;
    logic [WAIT_W-1:0]         wait_reg, wait_next;
    logic [CNT_W-1:0]          count_reg, count_next;
    logic [CNT_W-1:0]          cursor_reg, cursor_next;
    logic [cal_pkg::STATUS_W-1:0] pend_status_reg, pend_status_next;

    // result register
    logic                      out_valid_reg, out_valid_next;
    logic [cal_pkg::STATUS_W-1:0] out_status_reg;
    logic [7:0]                out_len_reg;
    logic [7:0]                out_cur_reg;
    logic [cal_pkg::VALUE_W-1:0] out_value_reg;
    logic                      out_cvalid_reg;

    logic accept;
    logic load;
    logic full;
    logic cur_valid;
    logic op_ins;
    logic op_app;
    logic [cal_pkg::STATUS_W-1:0] op_status;
    logic [CNT_W-1:0] op_count;
    logic [CNT_W-1:0] op_cursor;

    cal_pkg::cell_ctl_t    ctl;
    logic [DATA_WIDTH-1:0] wr_data;
    logic [DATA_WIDTH-1:0] cell_data [CAPACITY];
    logic [DATA_WIDTH-1:0] cell_rd   [CAPACITY];
    logic [DATA_WIDTH-1:0] root;

    assign s_tready  = (state_reg == cal_pkg::ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign full      = (count_reg == CAP_C);
    assign cur_valid = (cursor_reg < count_reg);

    // decode the operation against the present length and cursor
    always_comb begin
        op_ins    = 1'b0;
        op_app    = 1'b0;
        op_status = cal_pkg::STATUS_OK;
        op_count  = count_reg;
        op_cursor = cursor_reg;
        unique case (in_kind) inside
            cal_pkg::KIND_CLEAR: begin
                op_count  = '0;
                op_cursor = '0;
            end
            cal_pkg::KIND_INSERT, cal_pkg::KIND_APPEND: begin
                if (full) begin
                    op_status = cal_pkg::STATUS_FULL;
                end else begin
                    op_ins   = (in_kind == cal_pkg::KIND_INSERT);
                    op_app   = (in_kind == cal_pkg::KIND_APPEND);
                    op_count = count_reg + CNT_W'(1);
                end
            end
            cal_pkg::KIND_TO_START: begin
                op_cursor = '0;
            end
            cal_pkg::KIND_TO_END: begin
                op_cursor = count_reg;
            end
            cal_pkg::KIND_BACK: begin
                if (cursor_reg != '0) begin
                    op_cursor = cursor_reg - CNT_W'(1);
                end
            end
            cal_pkg::KIND_FORWARD: begin
                if (cur_valid) begin
                    op_cursor = cursor_reg + CNT_W'(1);
                end
            end
            cal_pkg::KIND_MOVE: begin
                if (CMP_W'(in_target) > CMP_W'(count_reg)) begin
                    op_status = cal_pkg::STATUS_RANGE;
                end else begin
                    op_cursor = CNT_W'(in_target);
                end
            end
            default: begin
                op_status = cal_pkg::STATUS_OK;
            end
        endcase
    end

    // broadcast to the cell row; cells change only on an accepted transaction
    assign ctl.ins   = accept && op_ins;
    assign ctl.app   = accept && op_app;
    assign ctl.rd_en = cur_valid;
    assign wr_data   = DATA_WIDTH'(in_value);

    genvar i;
    generate
        for (i = 0; i < CAPACITY; i++) begin : g_cell
            logic [DATA_WIDTH-1:0] left;
            if (i == 0) begin : g_first
                assign left = '0;
            end else begin : g_rest
                assign left = cell_data[i - 1];
            end
            cal_cell #(
                .IDX        (i),
                .CNT_W      (CNT_W),
                .DATA_WIDTH (DATA_WIDTH)
            ) u_cell (
                .aclk      (aclk),
                .ctl       (ctl),
                .cursor    (cursor_reg),
                .count     (count_reg),
                .wr_data   (wr_data),
                .left_data (left),
                .data      (cell_data[i]),
                .rd_data   (cell_rd[i])
            );
        end
    endgenerate

    cal_rd_tree #(
        .LEAVES (CAPACITY),
        .LVLS   (LVLS),
        .WIDTH  (DATA_WIDTH)
    ) u_rd_tree (
        .aclk (aclk),
        .leaf (cell_rd),
        .root (root)
    );

    // sequencer: idle, wait for the read tree, hold until the output frees
    always_comb begin
        state_next       = state_reg;
        wait_next        = wait_reg;
        count_next       = count_reg;
        cursor_next      = cursor_reg;
        pend_status_next = pend_status_reg;
        load             = 1'b0;
        unique case (state_reg)
            cal_pkg::ST_IDLE: begin
                if (accept) begin
                    count_next       = op_count;
                    cursor_next      = op_cursor;
                    pend_status_next = op_status;
                    wait_next        = WAIT_INI;
                    state_next       = cal_pkg::ST_BUSY;
                end
            end
            cal_pkg::ST_BUSY: begin
                if (wait_reg != '0) begin
                    wait_next = wait_reg - WAIT_W'(1);
                end else if (!out_valid_reg || m_tready) begin
                    load       = 1'b1;
                    state_next = cal_pkg::ST_IDLE;
                end else begin
                    state_next = cal_pkg::ST_HOLD;
                end
            end
            cal_pkg::ST_HOLD: begin
                if (m_tready) begin
                    load       = 1'b1;
                    state_next = cal_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = cal_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (load) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= cal_pkg::ST_IDLE;
            wait_reg      <= '0;
            count_reg     <= '0;
            cursor_reg    <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            wait_reg      <= wait_next;
            count_reg     <= count_next;
            cursor_reg    <= cursor_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers: no reset needed
    always_ff @(posedge aclk) begin
        pend_status_reg <= pend_status_next;
        if (load) begin
            out_status_reg <= pend_status_reg;
            out_len_reg    <= 8'(count_reg);
            out_cur_reg    <= 8'(cursor_reg);
            out_value_reg  <= cal_pkg::VALUE_W'(root);
            out_cvalid_reg <= cur_valid;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0, out_cvalid_reg, out_value_reg, out_cur_reg,
                       out_len_reg, out_status_reg};

endmodule

`default_nettype wire

// ===== test/cal_checker.sv =====
// ----------------------------------------------------------------------------
// cal_checker: result predictor and comparator for the cursor array list
// Mirrors the list on every accepted operation and compares each returned
// result, field by field, with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module cal_checker #(
    parameter int unsigned LIST_CAP = 128
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [47:0] s_tdata,
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [55:0] m_tdata,
    output int               mismatches,
    output int               reports_pending
);

    localparam int unsigned IDX_W = $clog2(LIST_CAP);

    // Same layout as m_tdata[50:0], highest field first
    typedef struct packed {
        logic        cursor_valid;
        logic [31:0] cursor_value;
        logic [7:0]  cursor_position;
        logic [7:0]  list_length;
        logic [1:0]  status;
    } list_report_t;

    logic [31:0]  entry_mirror [LIST_CAP];
    int unsigned  mirror_len;
    int unsigned  mirror_cursor;
    list_report_t reports_due [$];
    int           results_seen;

    initial begin
        mismatches      = 0;
        reports_pending = 0;
        mirror_len      = 0;
        mirror_cursor   = 0;
        results_seen    = 0;
    end

    task automatic log_mismatch(input string what);
        $display("cal_checker: result %0d: %s", results_seen, what);
        mismatches++;
    endtask

    // Apply one operation to the mirror and return the report it produces
    function automatic list_report_t apply_list_op(input logic [2:0] op,
                                                   input logic [31:0] value,
                                                   input logic [7:0] target);
        list_report_t rep;
        rep = '0;
        rep.status = cal_pkg::STATUS_OK;
        case (op)
            cal_pkg::KIND_CLEAR: begin
                mirror_len    = 0;
                mirror_cursor = 0;
            end
            cal_pkg::KIND_INSERT: begin
                if (mirror_len >= LIST_CAP) begin
                    rep.status = cal_pkg::STATUS_FULL;
                end else begin
                    for (int unsigned i = mirror_len; i > mirror_cursor; i--)
                        entry_mirror[IDX_W'(i)] = entry_mirror[IDX_W'(i - 1)];
                    entry_mirror[IDX_W'(mirror_cursor)] = value;
                    mirror_len++;
                end
            end
            cal_pkg::KIND_APPEND: begin
                if (mirror_len >= LIST_CAP) begin
                    rep.status = cal_pkg::STATUS_FULL;
                end else begin
                    entry_mirror[IDX_W'(mirror_len)] = value;
                    mirror_len++;
                end
            end
            cal_pkg::KIND_TO_START: mirror_cursor = 0;
            cal_pkg::KIND_TO_END:   mirror_cursor = mirror_len;
            cal_pkg::KIND_BACK: begin
                if (mirror_cursor != 0) mirror_cursor--;
            end
            cal_pkg::KIND_FORWARD: begin
                if (mirror_cursor < mirror_len) mirror_cursor++;
            end
            default: begin
                if (32'(target) > mirror_len) rep.status = cal_pkg::STATUS_RANGE;
                else mirror_cursor = 32'(target);
            end
        endcase
        rep.list_length     = mirror_len[7:0];
        rep.cursor_position = mirror_cursor[7:0];
        rep.cursor_valid    = (mirror_cursor < mirror_len);
        rep.cursor_value    = rep.cursor_valid ? entry_mirror[IDX_W'(mirror_cursor)] : '0;
        return rep;
    endfunction

    task automatic check_result(input logic [55:0] word);
        list_report_t got;
        list_report_t want;
        got = word[50:0];
        if (reports_due.size() == 0) begin
            log_mismatch("result arrived with no operation outstanding");
        end else begin
            want = reports_due.pop_front();
            if (got.status !== want.status)
                log_mismatch($sformatf("status %0d, expected %0d",
                                       got.status, want.status));
            if (got.list_length !== want.list_length)
                log_mismatch($sformatf("list_length %0d, expected %0d",
                                       got.list_length, want.list_length));
            if (got.cursor_position !== want.cursor_position)
                log_mismatch($sformatf("cursor_position %0d, expected %0d",
                                       got.cursor_position, want.cursor_position));
            if (got.cursor_value !== want.cursor_value)
                log_mismatch($sformatf("cursor_value %h, expected %h",
                                       got.cursor_value, want.cursor_value));
            if (got.cursor_valid !== want.cursor_valid)
                log_mismatch($sformatf("cursor_valid %b, expected %b",
                                       got.cursor_valid, want.cursor_valid));
        end
        results_seen++;
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            mirror_len    = 0;
            mirror_cursor = 0;
            reports_due.delete();
        end else begin
            if (m_tvalid && m_tready)
                check_result(m_tdata);
            if (s_tvalid && s_tready)
                reports_due.push_back(apply_list_op(s_tdata[2:0], s_tdata[34:3],
                                                    s_tdata[42:35]));
        end
        reports_pending <= reports_due.size();
    end

endmodule

// ===== test/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: testbench for the cursor array list
// Drives directed and random list operations with random idling on both
// channels; the checker predicts every result and counts mismatches.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int unsigned LIST_CAP    = 128;
    localparam int          TOTAL_ITEMS = 450;
    // Cycles with no transaction on either channel before the run is abandoned
    localparam int          STALL_LIMIT = 2000;

    logic        aclk;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    // [2:0] kind, [34:3] item_value, [42:35] target_position, [47:43] zero
    logic [47:0] s_tdata  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    // [1:0] status, [9:2] list_length, [17:10] cursor_position,
    // [49:18] cursor_value, [50] cursor_valid, [55:51] zero
    logic [55:0] m_tdata;

    int          mismatches;
    int          reports_pending;

    // Stimulus-side view of the list length, used only to shape sequences
    int unsigned shadow_len  = 0;
    int          items_sent  = 0;
    int          fills_done  = 0;
    bit          quiet       = 1'b0;   // no idling on either side
    bit          tx_idling   = 1'b1;
    bit          rx_idling   = 1'b1;
    int          rx_stall    = 0;
    int          idle_cycles = 0;

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    cursor_array_list #(
        .CAPACITY   (LIST_CAP),
        .DATA_WIDTH (32)
    ) DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    cal_checker #(
        .LIST_CAP (LIST_CAP)
    ) u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .mismatches      (mismatches),
        .reports_pending (reports_pending)
    );

    // Result side: stall in bursts of random length while idling is on,
    // flipping between idling and clean stretches now and then
    always @(posedge aclk) begin
        if ($urandom_range(0, 59) == 0) rx_idling = !rx_idling;
        if (rx_stall == 0 && rx_idling && !quiet && aresetn && $urandom_range(0, 4) == 0)
            rx_stall = $urandom_range(1, 9);
        if (rx_stall != 0) begin
            m_tready <= 1'b0;
            rx_stall--;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Watchdog: abandon the run when nothing moves on either channel
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("tb: failure");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic logic [31:0] entry_value();
        case ($urandom_range(0, 9))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // Target in range most of the time, anywhere up to 128 otherwise
    function automatic logic [7:0] nav_target();
        if ($urandom_range(0, 3) != 0) return 8'($urandom_range(0, shadow_len));
        return 8'($urandom_range(0, 128));
    endfunction

    // Present one operation and hold it until accepted; unless idling, leave
    // tvalid high so back-to-back transactions need no second assignment in a step
    task automatic send_op(input logic [2:0] op, input logic [31:0] value,
                           input logic [7:0] target);
        s_tvalid <= 1'b1;
        s_tdata  <= {5'b0, target, value, op};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        items_sent++;
        case (op) inside
            cal_pkg::KIND_CLEAR: shadow_len = 0;
            cal_pkg::KIND_INSERT, cal_pkg::KIND_APPEND: begin
                if (shadow_len < LIST_CAP) shadow_len++;
            end
            default: ;
        endcase
        if ($urandom_range(0, 39) == 0) tx_idling = !tx_idling;
        if (!quiet && tx_idling && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge aclk);
        end
    endtask

    // Hold off the sender until every outstanding result has returned
    task automatic drain_results();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (reports_pending != 0);
    endtask

    task automatic grow_op();
        send_op($urandom_range(0, 1) ? cal_pkg::KIND_INSERT : cal_pkg::KIND_APPEND,
                entry_value(), 8'($urandom_range(0, 128)));
    endtask

    task automatic move_op();
        send_op(3'($urandom_range(cal_pkg::KIND_TO_START, cal_pkg::KIND_MOVE)),
                $urandom, nav_target());
    endtask

    // Fill the list to capacity with cursor moves mixed in, then push
    // against the full list, park the cursor at the very end and make one more move
    task automatic fill_list();
        while (shadow_len < LIST_CAP) begin
            if ($urandom_range(0, 5) == 0) move_op();
            else grow_op();
        end
        repeat ($urandom_range(1, 3)) grow_op();
        send_op(cal_pkg::KIND_MOVE, $urandom, 8'd128);
        send_op(cal_pkg::KIND_FORWARD, $urandom, 8'($urandom_range(0, 128)));
        send_op(cal_pkg::KIND_INSERT, entry_value(), 8'($urandom_range(0, 128)));
        move_op();
        fills_done++;
    endtask

    initial begin
        int pick;

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: empty-list edges, both ends of the data, every kind
        send_op(cal_pkg::KIND_MOVE,     32'h1234_5678, 8'd0);     // move to the length
        send_op(cal_pkg::KIND_MOVE,     32'h0,         8'd1);     // beyond the length
        send_op(cal_pkg::KIND_MOVE,     32'h0,         8'd128);   // top of the target range
        send_op(cal_pkg::KIND_BACK,     $urandom,      8'd77);    // back at start
        send_op(cal_pkg::KIND_FORWARD,  $urandom,      8'd5);     // forward at end
        send_op(cal_pkg::KIND_TO_END,   $urandom,      8'd0);
        send_op(cal_pkg::KIND_APPEND,   32'h0000_0000, 8'd255 >> 1);
        send_op(cal_pkg::KIND_APPEND,   32'hFFFF_FFFF, 8'd0);
        send_op(cal_pkg::KIND_INSERT,   32'h5A5A_5A5A, 8'd0);     // insert at the head
        send_op(cal_pkg::KIND_FORWARD,  $urandom,      8'd0);
        send_op(cal_pkg::KIND_FORWARD,  $urandom,      8'd0);
        send_op(cal_pkg::KIND_INSERT,   32'h8000_0001, 8'd0);     // insert mid-list
        send_op(cal_pkg::KIND_TO_END,   $urandom,      8'd0);
        send_op(cal_pkg::KIND_INSERT,   32'h0000_0001, 8'd0);     // insert at the tail
        send_op(cal_pkg::KIND_FORWARD,  $urandom,      8'd0);
        send_op(cal_pkg::KIND_FORWARD,  $urandom,      8'd0);
        send_op(cal_pkg::KIND_BACK,     $urandom,      8'd0);
        send_op(cal_pkg::KIND_MOVE,     $urandom,      8'd5);
        send_op(cal_pkg::KIND_MOVE,     $urandom,      8'd6);
        send_op(cal_pkg::KIND_MOVE,     $urandom,      8'd2);
        send_op(cal_pkg::KIND_TO_START, $urandom,      8'd0);
        send_op(cal_pkg::KIND_BACK,     $urandom,      8'd0);
        send_op(cal_pkg::KIND_CLEAR,    $urandom,      8'd128);
        send_op(cal_pkg::KIND_TO_END,   $urandom,      8'd0);
        send_op(cal_pkg::KIND_FORWARD,  $urandom,      8'd0);
        drain_results();

        // Random: mostly well-formed growth and navigation, some noise,
        // at least one run all the way to a full list; a fill only starts
        // while there is room for it within the item budget
        while (items_sent < TOTAL_ITEMS) begin
            if (items_sent >= TOTAL_ITEMS - 40) quiet = 1'b1;
            pick = $urandom_range(0, 99);
            if (shadow_len < LIST_CAP && items_sent + 2 * LIST_CAP < TOTAL_ITEMS &&
                (pick < 6 || (fills_done == 0 && items_sent > 150))) begin
                fill_list();
                if (fills_done == 1) drain_results();
            end else if (pick < (shadow_len == LIST_CAP ? 50 : 12)) begin
                send_op(cal_pkg::KIND_CLEAR, $urandom, 8'($urandom_range(0, 128)));
            end else if (pick < 55) begin
                repeat ($urandom_range(1, 10)) grow_op();
            end else if (pick < 88) begin
                repeat ($urandom_range(1, 8)) move_op();
            end else begin
                repeat ($urandom_range(1, 3))
                    send_op(3'($urandom_range(0, 7)), $urandom,
                            8'($urandom_range(0, 128)));
            end
        end

        // Drain, then allow the read tree time to surface any stray result
        quiet = 1'b1;
        drain_results();
        repeat (20) @(posedge aclk);

        if (mismatches == 0 && reports_pending == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
src/cal_pkg.sv
src/cal_cell.sv
src/cal_rd_tree.sv
src/cursor_array_list.sv
test/cal_checker.sv
test/tb_top.sv
